### hdl/lpfd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Length-prefixed frame deframer package
// Types, codes and constants shared by the deframer modules.
// ----------------------------------------------------------------------------
package lpfd_pkg;

  localparam int HDR_BYTES   = 20;
  localparam int HDR_BITS    = HDR_BYTES * 8;
  localparam int HDR_IDX_W   = $clog2(HDR_BYTES);
  localparam int LIMIT_W     = 31;
  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W  = 32;

  localparam logic [HDR_IDX_W-1:0] HDR_LAST = HDR_IDX_W'(HDR_BYTES - 1);

  localparam logic [LIMIT_W-1:0] RST_MAX_LENGTH    = LIMIT_W'(10 * 1024 * 1024);
  localparam logic [LIMIT_W-1:0] RST_MAX_DIMENSION = LIMIT_W'(8192);

  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_LENGTH    = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_MAX_DIMENSION = CFG_INDEX_W'(1);

  localparam logic OP_STREAM_BYTE = 1'b0;
  localparam logic OP_NEW_CONN    = 1'b1;

  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_ERROR   = 2'd2;

  localparam logic ERR_LENGTH     = 1'b0;
  localparam logic ERR_DIMENSIONS = 1'b1;

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_PAYLOAD = 2'd1,
    PH_ERROR   = 2'd2
  } phase_t;

  typedef struct packed {
    logic       operation;
    logic [7:0] data_byte;
  } item_t;

  typedef struct packed {
    logic [LIMIT_W-1:0] max_length;
    logic [LIMIT_W-1:0] max_dimension;
  } limits_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [7:0]         payload_byte;
    logic               last_of_frame;
    logic [LIMIT_W-1:0] frame_length;
    logic [LIMIT_W-1:0] frame_width;
    logic [LIMIT_W-1:0] frame_height;
    logic [63:0]        timestamp_us;
    logic               error_code;
  } result_t;

  // True for a positive signed 32-bit value no greater than the limit.
  function automatic logic in_range(input logic [31:0] v, input logic [LIMIT_W-1:0] limit);
    in_range = !v[31] && (v[LIMIT_W-1:0] != '0) && (v[LIMIT_W-1:0] <= limit);
  endfunction

endpackage

### hdl/lpfd_intf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Length-prefixed frame deframer channel interfaces
// Byte input channel, result channel and register write channel.
// ----------------------------------------------------------------------------
interface lpfd_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] data_byte;

  modport source (output valid, output operation, output data_byte, input ready);
  modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

interface lpfd_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         kind;
  logic [7:0]         payload_byte;
  logic               last_of_frame;
  logic [30:0]        frame_length;
  logic [30:0]        frame_width;
  logic [30:0]        frame_height;
  logic signed [63:0] timestamp_us;
  logic               error_code;

  modport source (output valid, output kind, output payload_byte, output last_of_frame,
                  output frame_length, output frame_width, output frame_height,
                  output timestamp_us, output error_code, input ready);
  modport sink   (input valid, input kind, input payload_byte, input last_of_frame,
                  input frame_length, input frame_width, input frame_height,
                  input timestamp_us, input error_code, output ready);
endinterface

interface lpfd_cfg_if;
  logic        valid;
  logic        ready;
  logic [7:0]  index;
  logic [31:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

### hdl/lpfd_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deframer limit registers
// Holds the maximum length and maximum dimension written over the config port.
// ----------------------------------------------------------------------------
module lpfd_cfg
  import lpfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  lpfd_cfg_if.sink    cfg_ch,
  output limits_t     limits
);

  limits_t limits_r;
  limits_t limits_nxt;

  assign cfg_ch.ready = 1'b1;
  assign limits       = limits_r;

  always_comb begin
    limits_nxt = limits_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        CFG_MAX_LENGTH:    limits_nxt.max_length    = cfg_ch.data[LIMIT_W-1:0];
        CFG_MAX_DIMENSION: limits_nxt.max_dimension = cfg_ch.data[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limits_r.max_length    <= RST_MAX_LENGTH;
      limits_r.max_dimension <= RST_MAX_DIMENSION;
    end else begin
      limits_r <= limits_nxt;
    end
  end

endmodule

### hdl/lpfd_in_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deframer input register
// Registers one request from the byte channel and hands it to the parser.
// ----------------------------------------------------------------------------
module lpfd_in_stage
  import lpfd_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  lpfd_in_if.sink  in_ch,
  input  logic     take,
  output logic     item_valid,
  output item_t    item
);

  logic  valid_r;
  logic  valid_nxt;
  item_t item_r;
  logic  load;

  assign in_ch.ready = !valid_r || take;
  assign load        = in_ch.valid && in_ch.ready;
  assign item_valid  = valid_r;
  assign item        = item_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      item_r.operation <= in_ch.operation;
      item_r.data_byte <= in_ch.data_byte;
    end
  end

endmodule

### hdl/lpfd_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deframer parser and result register
// Collects the header, checks it, forwards payload bytes and holds the result.
// ----------------------------------------------------------------------------
module lpfd_core
  import lpfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        item_valid,
  input  item_t       item,
  input  limits_t     limits,
  output logic        take,
  lpfd_out_if.source  out_ch
);

  phase_t                 phase_r;
  phase_t                 phase_nxt;
  logic [HDR_IDX_W-1:0]   idx_r;
  logic [HDR_IDX_W-1:0]   idx_nxt;
  logic [LIMIT_W-1:0]     rem_r;
  logic [LIMIT_W-1:0]     rem_nxt;
  logic [HDR_BITS-1:0]    hdr_r;
  logic [HDR_BITS-1:0]    hdr_nxt;
  logic [HDR_BITS-1:0]    hdr_shift;
  logic                   out_valid_r;
  logic                   out_valid_nxt;
  result_t                res_r;
  result_t                res_nxt;
  logic                   gen;
  logic                   fire;
  logic [31:0]            hdr_len;
  logic [31:0]            hdr_w;
  logic [31:0]            hdr_h;
  logic                   len_ok;
  logic                   dim_ok;

  assign take      = !out_valid_r || out_ch.ready;
  assign fire      = item_valid && take;
  assign hdr_shift = {hdr_r[HDR_BITS-9:0], item.data_byte};
  assign hdr_len   = hdr_shift[HDR_BITS-1 -: 32];
  assign hdr_w     = hdr_shift[HDR_BITS-33 -: 32];
  assign hdr_h     = hdr_shift[HDR_BITS-65 -: 32];
  assign len_ok    = in_range(hdr_len, limits.max_length);
  assign dim_ok    = in_range(hdr_w, limits.max_dimension) &&
                     in_range(hdr_h, limits.max_dimension);

  always_comb begin
    phase_nxt = phase_r;
    idx_nxt   = idx_r;
    rem_nxt   = rem_r;
    hdr_nxt   = hdr_r;
    res_nxt   = '0;
    gen       = 1'b0;
    if (fire) begin
      if (item.operation == OP_NEW_CONN) begin
        phase_nxt = PH_HEADER;
        idx_nxt   = '0;
        rem_nxt   = '0;
      end else begin
        case (phase_r)
          PH_HEADER: begin
            hdr_nxt = hdr_shift;
            if (idx_r >= HDR_LAST) begin
              idx_nxt = '0;
              gen     = 1'b1;
              if (!len_ok) begin
                phase_nxt          = PH_ERROR;
                res_nxt.kind       = KIND_ERROR;
                res_nxt.error_code = ERR_LENGTH;
              end else if (!dim_ok) begin
                phase_nxt          = PH_ERROR;
                res_nxt.kind       = KIND_ERROR;
                res_nxt.error_code = ERR_DIMENSIONS;
              end else begin
                phase_nxt            = PH_PAYLOAD;
                rem_nxt              = hdr_len[LIMIT_W-1:0];
                res_nxt.kind         = KIND_HEADER;
                res_nxt.frame_length = hdr_len[LIMIT_W-1:0];
                res_nxt.frame_width  = hdr_w[LIMIT_W-1:0];
                res_nxt.frame_height = hdr_h[LIMIT_W-1:0];
                res_nxt.timestamp_us = hdr_shift[63:0];
              end
            end else begin
              idx_nxt = idx_r + 1'b1;
            end
          end
          PH_PAYLOAD: begin
            gen                  = 1'b1;
            res_nxt.kind         = KIND_PAYLOAD;
            res_nxt.payload_byte = item.data_byte;
            if (rem_r <= LIMIT_W'(1)) begin
              res_nxt.last_of_frame = 1'b1;
              rem_nxt               = '0;
              phase_nxt             = PH_HEADER;
              idx_nxt               = '0;
            end else begin
              rem_nxt = rem_r - 1'b1;
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (gen) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HEADER;
      idx_r       <= '0;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      idx_r       <= idx_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hdr_r <= hdr_nxt;
    if (gen) begin
      res_r <= res_nxt;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.kind          = res_r.kind;
  assign out_ch.payload_byte  = res_r.payload_byte;
  assign out_ch.last_of_frame = res_r.last_of_frame;
  assign out_ch.frame_length  = res_r.frame_length;
  assign out_ch.frame_width   = res_r.frame_width;
  assign out_ch.frame_height  = res_r.frame_height;
  assign out_ch.timestamp_us  = res_r.timestamp_us;
  assign out_ch.error_code    = res_r.error_code;

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    idx_r <= HDR_LAST)
    else $error("Header index ran past the header length.");

  a_payload_pending: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_PAYLOAD |-> rem_r != '0)
    else $error("Payload phase entered with no bytes pending.");

  a_header_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    gen && (res_nxt.kind == KIND_HEADER || res_nxt.kind == KIND_ERROR)
      |-> phase_r == PH_HEADER && idx_r == HDR_LAST)
    else $error("Header verdict issued before the header was complete.");

  a_header_starts_payload: assert property (@(posedge clk) disable iff (!rst_n)
    gen && res_nxt.kind == KIND_HEADER |=> phase_r == PH_PAYLOAD && rem_r == res_r.frame_length)
    else $error("Accepted header did not start the payload phase.");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !gen)
    else $error("Result overwritten while the receiver was stalled.");

endmodule

### hdl/length_prefixed_frame_deframer_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Length-prefixed frame deframer
// Splits a byte stream into checked frame headers and payload bytes.
//
// Requests arrive on in_ch, one stream byte or one new-connection marker each.
// Results leave on out_ch: a header request after 20 valid header bytes, one
// request per payload byte with the final byte marked, or a single error
// request after which bytes are dropped until the next new connection.
// The limits are written on cfg_ch, which is always ready; the user writes them
// only while idle, which the block itself does not enforce. A request is
// registered at the input, processed combinationally and held in the result
// register. While the receiver keeps taking results, the block takes one
// request per cycle; the input register and the result register let a new
// byte be accepted while a result waits to be taken.
// When the receiver stalls, the held result stays and at most one more input
// request is buffered before in_ch.ready drops. Reset returns to header
// collection, empties both registers and loads the default limits.
// ----------------------------------------------------------------------------
module length_prefixed_frame_deframer_top
  import lpfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  lpfd_in_if.sink     in_ch,
  lpfd_out_if.source  out_ch,
  lpfd_cfg_if.sink    cfg_ch
);

  limits_t limits;
  item_t   item;
  logic    item_valid;
  logic    take;

  lpfd_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .limits (limits)
  );

  lpfd_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .take       (take),
    .item_valid (item_valid),
    .item       (item)
  );

  lpfd_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item       (item),
    .limits     (limits),
    .take       (take),
    .out_ch     (out_ch)
  );

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Length-prefixed frame deframer testbench
// Drives byte and new-connection requests into the deframer and predicts every
// header, payload and error result from its own copy of the parse state.
// Directed tests cover the field extremes, the range checks, new connections,
// register writes and a long receiver hold-off. A random phase follows that
// runs well-formed frames mixed with bad headers, truncated frames and noise
// under several limit settings, with random stalls and sender pauses.
// ----------------------------------------------------------------------------
module tb_top;
  import lpfd_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int RANDOM_ITEMS   = 1500;
  localparam int DRAIN_CYCLES   = 4;
  localparam int HOLD_CYCLES    = 60;
  localparam int MAX_GAP        = 17;

  localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_UNUSED = CFG_MAX_DIMENSION + 1'b1;
  localparam logic [CFG_INDEX_W-1:0] CFG_INDEX_TOP    = '1;

  logic clk;
  logic rst_n;

  lpfd_in_if  in_ch ();
  lpfd_out_if out_ch ();
  lpfd_cfg_if cfg_ch ();

  length_prefixed_frame_deframer_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  phase_t             parse_phase;
  int unsigned        hdr_count;
  logic [7:0]         hdr_buf [HDR_BYTES];
  logic [LIMIT_W-1:0] bytes_left;
  logic [LIMIT_W-1:0] lim_length;
  logic [LIMIT_W-1:0] lim_dim;
  result_t            frame_results_q [$];

  int unsigned tx_max;
  int unsigned rx_max;
  int unsigned hold_req;
  int unsigned items_sent;
  int unsigned results_seen;
  int unsigned n_headers;
  int unsigned n_payload;
  int unsigned n_errors;
  int unsigned errors;
  int unsigned idle_cycles;

  always #1 clk = ~clk;

  function automatic logic fits_limit(logic [31:0] v, logic [LIMIT_W-1:0] lim);
    return (v != 32'd0) && !v[31] && (v[LIMIT_W-1:0] <= lim);
  endfunction

  task automatic predict_deframe(logic op, logic [7:0] b);
    result_t     r;
    logic [31:0] len;
    logic [31:0] wid;
    logic [31:0] hgt;
    r = '0;
    if (op == OP_NEW_CONN) begin
      parse_phase = PH_HEADER;
      hdr_count   = 0;
      bytes_left  = '0;
      return;
    end
    case (parse_phase)
      PH_HEADER: begin
        hdr_buf[hdr_count] = b;
        hdr_count++;
        if (hdr_count == HDR_BYTES) begin
          hdr_count = 0;
          len = {hdr_buf[0], hdr_buf[1], hdr_buf[2], hdr_buf[3]};
          wid = {hdr_buf[4], hdr_buf[5], hdr_buf[6], hdr_buf[7]};
          hgt = {hdr_buf[8], hdr_buf[9], hdr_buf[10], hdr_buf[11]};
          if (!fits_limit(len, lim_length)) begin
            parse_phase  = PH_ERROR;
            r.kind       = KIND_ERROR;
            r.error_code = ERR_LENGTH;
          end else if (!fits_limit(wid, lim_dim) || !fits_limit(hgt, lim_dim)) begin
            parse_phase  = PH_ERROR;
            r.kind       = KIND_ERROR;
            r.error_code = ERR_DIMENSIONS;
          end else begin
            parse_phase    = PH_PAYLOAD;
            bytes_left     = len[LIMIT_W-1:0];
            r.kind         = KIND_HEADER;
            r.frame_length = len[LIMIT_W-1:0];
            r.frame_width  = wid[LIMIT_W-1:0];
            r.frame_height = hgt[LIMIT_W-1:0];
            r.timestamp_us = {hdr_buf[12], hdr_buf[13], hdr_buf[14], hdr_buf[15],
                              hdr_buf[16], hdr_buf[17], hdr_buf[18], hdr_buf[19]};
          end
          frame_results_q.push_back(r);
        end
      end
      PH_PAYLOAD: begin
        r.kind         = KIND_PAYLOAD;
        r.payload_byte = b;
        if (bytes_left <= 1) begin
          r.last_of_frame = 1'b1;
          bytes_left      = '0;
          parse_phase     = PH_HEADER;
          hdr_count       = 0;
        end else begin
          bytes_left--;
        end
        frame_results_q.push_back(r);
      end
      default: begin
      end
    endcase
  endtask

  task automatic send_item(logic op, logic [7:0] b);
    int unsigned gap;
    gap = $urandom_range(tx_max);
    @(negedge clk);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.operation <= op;
    in_ch.data_byte <= b;
    do @(posedge clk); while (!in_ch.ready);
    predict_deframe(op, b);
    items_sent++;
  endtask

  task automatic send_header_bytes(logic [HDR_BITS-1:0] hdr, int first, int count);
    for (int i = first; i < first + count; i++) begin
      send_item(OP_STREAM_BYTE, hdr[HDR_BITS-1-8*i -: 8]);
    end
  endtask

  task automatic send_header(logic [31:0] len, logic [31:0] wid, logic [31:0] hgt,
                             logic [63:0] ts);
    send_header_bytes({len, wid, hgt, ts}, 0, HDR_BYTES);
  endtask

  task automatic send_payload(int unsigned n);
    repeat (n) send_item(OP_STREAM_BYTE, 8'($urandom_range(255)));
  endtask

  task automatic new_connection();
    send_item(OP_NEW_CONN, 8'($urandom_range(255)));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (frame_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    if (idx == CFG_MAX_LENGTH) begin
      lim_length = val[LIMIT_W-1:0];
    end else if (idx == CFG_MAX_DIMENSION) begin
      lim_dim = val[LIMIT_W-1:0];
    end
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic set_limits(logic [CFG_DATA_W-1:0] len_lim, logic [CFG_DATA_W-1:0] dim_lim);
    wait_idle();
    write_reg(CFG_MAX_LENGTH, len_lim);
    write_reg(CFG_MAX_DIMENSION, dim_lim);
  endtask

  task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      errors++;
    end
  endtask

  task automatic check_result();
    result_t got;
    result_t want;
    got.kind          = out_ch.kind;
    got.payload_byte  = out_ch.payload_byte;
    got.last_of_frame = out_ch.last_of_frame;
    got.frame_length  = out_ch.frame_length;
    got.frame_width   = out_ch.frame_width;
    got.frame_height  = out_ch.frame_height;
    got.timestamp_us  = out_ch.timestamp_us;
    got.error_code    = out_ch.error_code;
    results_seen++;
    case (got.kind)
      KIND_HEADER:  n_headers++;
      KIND_PAYLOAD: n_payload++;
      default:      n_errors++;
    endcase
    if (frame_results_q.size() == 0) begin
      $error("unexpected result of kind %0d", got.kind);
      errors++;
      return;
    end
    want = frame_results_q.pop_front();
    check_field("kind", want.kind, got.kind);
    check_field("payload_byte", want.payload_byte, got.payload_byte);
    check_field("last_of_frame", want.last_of_frame, got.last_of_frame);
    check_field("frame_length", want.frame_length, got.frame_length);
    check_field("frame_width", want.frame_width, got.frame_width);
    check_field("frame_height", want.frame_height, got.frame_height);
    check_field("timestamp_us", want.timestamp_us, got.timestamp_us);
    check_field("error_code", want.error_code, got.error_code);
  endtask

  function automatic logic [31:0] pick_length();
    int unsigned cap;
    cap = ($urandom_range(19) == 0) ? 300 : 16;
    if (lim_length < cap) begin
      cap = lim_length;
    end
    return $urandom_range(1, cap);
  endfunction

  function automatic logic [31:0] pick_dim();
    if ($urandom_range(7) == 0) begin
      return {1'b0, lim_dim};
    end
    return $urandom_range(1, lim_dim);
  endfunction

  function automatic logic [31:0] pick_bad(logic [LIMIT_W-1:0] lim);
    case ($urandom_range(3))
      0:       return 32'd0;
      1:       return {1'b1, 31'($urandom)};
      2:       return {1'b0, lim} + 32'd1;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_reset_defaults();
    tx_max = 0;
    rx_max = 0;
    send_header(32'd1, 32'd8192, 32'd8192, 64'h8000_0000_0000_0000);
    send_payload(1);
    send_header(32'd2, 32'd1, 32'd1, 64'h7FFF_FFFF_FFFF_FFFF);
    send_item(OP_STREAM_BYTE, 8'h00);
    send_item(OP_STREAM_BYTE, 8'hFF);
    send_header(32'd10485760, 32'd1, 32'd8193, 64'hFFFF_FFFF_FFFF_FFFF);
    send_payload(3);
    new_connection();
    send_header(32'd10485761, 32'd1, 32'd1, 64'd0);
    new_connection();
    send_header(32'd3, 32'd0, 32'd5, 64'd0);
    new_connection();
    send_header(32'd3, 32'd5, 32'hFFFF_FFFF, 64'd0);
    new_connection();
  endtask

  task automatic test_length_checks();
    tx_max = MAX_GAP;
    rx_max = MAX_GAP;
    send_header(32'd0, 32'd1, 32'd1, 64'd0);
    new_connection();
    send_header(32'h8000_0000, 32'd1, 32'd1, 64'd0);
    new_connection();
    send_header(32'hFFFF_FFFF, 32'd1, 32'd1, 64'd0);
    new_connection();
    send_header(32'd0, 32'd0, 32'h8000_0000, 64'd0);
    send_payload(2);
    new_connection();
  endtask

  task automatic test_new_connection();
    tx_max = 3;
    rx_max = 3;
    send_header_bytes({$urandom, $urandom, $urandom, $urandom, $urandom}, 0, 7);
    new_connection();
    new_connection();
    send_header(32'd4, 32'd640, 32'd480, {$urandom, $urandom});
    send_payload(2);
    new_connection();
    send_header(32'd1, 32'd640, 32'd480, {$urandom, $urandom});
    send_payload(1);
  endtask

  task automatic test_register_writes();
    rx_max = MAX_GAP;
    tx_max = 0;
    set_limits(32'd3, 32'd1);
    send_header(32'd3, 32'd1, 32'd1, 64'd5);
    send_payload(3);
    send_header(32'd4, 32'd1, 32'd1, 64'd5);
    new_connection();
    send_header(32'd3, 32'd2, 32'd1, 64'd5);
    new_connection();
    set_limits(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_header(32'd2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 64'd9);
    send_payload(2);
    set_limits(32'd0, 32'd0);
    send_header(32'd1, 32'd1, 32'd1, 64'd0);
    new_connection();
    wait_idle();
    write_reg(CFG_MAX_LENGTH, 32'd5);
    send_header(32'd1, 32'd1, 32'd1, 64'd0);
    new_connection();
    set_limits(32'd100, 32'd100);
    write_reg(CFG_INDEX_UNUSED, 32'd0);
    write_reg(CFG_INDEX_TOP, 32'd0);
    send_header(32'd1, 32'd100, 32'd100, 64'd1);
    send_payload(1);
    send_header_bytes({32'd5, 32'd1, 32'd1, 64'd0}, 0, 10);
    wait_idle();
    write_reg(CFG_MAX_LENGTH, 32'd4);
    send_header_bytes({32'd5, 32'd1, 32'd1, 64'd0}, 10, 10);
    new_connection();
    set_limits({1'b0, RST_MAX_LENGTH}, {1'b0, RST_MAX_DIMENSION});
  endtask

  task automatic test_backpressure();
    tx_max   = 0;
    rx_max   = 0;
    hold_req = HOLD_CYCLES;
    send_header(32'd40, 32'd16, 32'd16, {$urandom, $urandom});
    send_payload(40);
    wait_idle();
  endtask

  task automatic test_random();
    int unsigned stop_at;
    int unsigned len;
    logic [31:0] len_lim [6];
    logic [31:0] dim_lim [6];
    len_lim = '{{1'b0, RST_MAX_LENGTH}, 32'd16, 32'h7FFF_FFFF, 32'd1,
                $urandom_range(1, 1000), 32'h7FFF_FFFF};
    dim_lim = '{{1'b0, RST_MAX_DIMENSION}, 32'd64, 32'h7FFF_FFFF, 32'd1,
                $urandom_range(1, 1000), 32'd1};
    for (int s = 0; s < 6; s++) begin
      set_limits(len_lim[s], dim_lim[s]);
      stop_at = items_sent + RANDOM_ITEMS / 6;
      while (items_sent < stop_at) begin
        tx_max = ($urandom_range(3) == 0) ? 0 : MAX_GAP;
        rx_max = ($urandom_range(3) == 0) ? 0 : MAX_GAP;
        if ($urandom_range(15) == 0) begin
          wait_idle();
        end
        case ($urandom_range(19))
          0, 1: begin
            if ($urandom_range(1) == 0) begin
              send_header(pick_bad(lim_length), pick_dim(), pick_dim(), {$urandom, $urandom});
            end else begin
              send_header(pick_length(), pick_bad(lim_dim), pick_dim(), {$urandom, $urandom});
            end
            send_payload($urandom_range(5));
            new_connection();
          end
          2: begin
            repeat ($urandom_range(1, 30)) begin
              send_item(($urandom_range(7) == 0) ? OP_NEW_CONN : OP_STREAM_BYTE,
                        8'($urandom_range(255)));
            end
            new_connection();
          end
          3: begin
            len = pick_length();
            send_header(len, pick_dim(), pick_dim(), {$urandom, $urandom});
            send_payload($urandom_range(len - 1));
            new_connection();
          end
          default: begin
            len = pick_length();
            send_header(len, pick_dim(), pick_dim(), {$urandom, $urandom});
            send_payload(len);
          end
        endcase
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_top: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : result_side
    int unsigned gap;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_req != 0) begin
        gap      = hold_req;
        hold_req = 0;
      end else begin
        gap = $urandom_range(rx_max);
      end
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      check_result();
    end
  end

  initial begin
    clk              = 1'b0;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.operation  = OP_STREAM_BYTE;
    in_ch.data_byte  = 8'h00;
    out_ch.ready     = 1'b0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = CFG_MAX_LENGTH;
    cfg_ch.data      = '0;
    parse_phase      = PH_HEADER;
    hdr_count        = 0;
    bytes_left       = '0;
    lim_length       = RST_MAX_LENGTH;
    lim_dim          = RST_MAX_DIMENSION;
    tx_max           = 0;
    rx_max           = 0;
    hold_req         = 0;
    items_sent       = 0;
    results_seen     = 0;
    n_headers        = 0;
    n_payload        = 0;
    n_errors         = 0;
    errors           = 0;
    idle_cycles      = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_length_checks();
    test_new_connection();
    test_register_writes();
    test_backpressure();
    test_random();

    wait_idle();
    $display("tb_top: %0d requests sent, %0d results checked: %0d headers, %0d payload bytes,",
             items_sent, results_seen, n_headers, n_payload);
    $display("tb_top: %0d framing errors, under default, tiny, zero and full-range limits",
             n_errors);
    if (errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
